@@ design/particle_systematic_resampler_defines.svh @@
// Assertion macros shared by the particle systematic resampler RTL.
`ifndef PARTICLE_SYSTEMATIC_RESAMPLER_DEFINES_SVH
`define PARTICLE_SYSTEMATIC_RESAMPLER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define PSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PSR_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define PSR_ASSERT(lbl, prop, msg)
`define PSR_NEVER(lbl, expr, msg)
`endif
`endif

@@ design/psr_pkg.sv @@
// Types and constants of the particle systematic resampler.
`timescale 1ns / 1ps
package psr_pkg;

  localparam int unsigned PARTICLES   = 64;
  localparam int unsigned IDX_W       = $clog2(PARTICLES);
  localparam int unsigned CNT_W       = $clog2(PARTICLES + 1);
  localparam int unsigned WEIGHT_W    = 17;
  localparam int unsigned OFF_W       = 10;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 8;
  localparam int unsigned SQR_W       = 2 * WEIGHT_W;
  localparam int unsigned SQ_W        = 40;
  localparam int unsigned PROD_W      = SQ_W + CNT_W;
  localparam logic [PROD_W-1:0] THRESH = PROD_W'(1) << 33;
  localparam int unsigned BASE_W      = 16;
  localparam int unsigned MAX_OFF     = 65535 / PARTICLES;
  localparam int unsigned STEP        = 65536;
  localparam int unsigned CUM_W       = $clog2(131071 * PARTICLES * PARTICLES + 1);
  localparam int unsigned PTR_W       = $clog2(PARTICLES * STEP);
  localparam int unsigned WALK_W      = (CUM_W > PTR_W) ? CUM_W : PTR_W;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_START = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SKIP,
    ST_RD,
    ST_ACC,
    ST_CMP
  } walk_state_e;

  typedef struct packed {
    logic [BASE_W-1:0] base;
    logic              resample;
    logic [CNT_W-1:0]  cnt;
  } cmd_t;

  typedef struct packed {
    logic                en;
    logic [IDX_W-1:0]    addr;
    logic [WEIGHT_W-1:0] data;
  } ram_wr_t;

endpackage

@@ design/particle_systematic_resampler.sv @@
// Top level of the particle systematic resampler.
// Input stream: each request is a weight load (tuser = 0, Q1.16 weight in tdata[16:0]) or a
// start (tuser = 1, random offset in tdata[26:17]). Loads give no output; loads past the
// particle count are accepted and dropped.
// A start gives either one result with resampled = 0 and tlast set, or one result per
// output slot carrying the chosen source index with resampled = 1, the last one with tlast.
// The decision is formed from the registered start and waits in a two-entry command queue.
// The walk engine then steps through three states for each particle it steps past (store
// read, accumulate, compare) and gives one result per output slot.
// Loads of the next run are held off while a run still reads the weight store; starts are
// taken while no decision is pending.
// Reset clears the load count, the sum of squares, the queue and the output valid flag.
// A stalled receiver holds the result register; the walk waits until it can be written.
`timescale 1ns / 1ps
`include "particle_systematic_resampler_defines.svh"
module particle_systematic_resampler (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // weight [16:0], start_offset [26:17], zero fill above
  input  logic [psr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind [0]
  input  logic                             s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // source_index [5:0], zero fill above
  output logic [psr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  // resampled [0]
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast
);

  psr_pkg::cmd_t                  cmd_in;
  psr_pkg::cmd_t                  cmd_out;
  psr_pkg::ram_wr_t               ram_wr;
  logic                           cmd_push;
  logic                           cmd_pop;
  logic                           q_full;
  logic                           q_empty;
  logic                           back_busy;
  logic                           rd_en;
  logic [psr_pkg::IDX_W-1:0]      rd_addr;
  logic [psr_pkg::WEIGHT_W-1:0]   rd_data;

  psr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .back_busy_i   (back_busy),
    .q_empty_i     (q_empty),
    .q_full_i      (q_full),
    .cmd_push_o    (cmd_push),
    .cmd_o         (cmd_in),
    .ram_wr_o      (ram_wr)
  );

  psr_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (q_full),
    .empty_o (q_empty),
    .pop_i   (cmd_pop),
    .data_o  (cmd_out)
  );

  psr_ram #(
    .DATA_W (psr_pkg::WEIGHT_W),
    .DEPTH  (psr_pkg::PARTICLES)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (ram_wr.en),
    .waddr_i (ram_wr.addr),
    .wdata_i (ram_wr.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  psr_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .cmd_i         (cmd_out),
    .pop_o         (cmd_pop),
    .busy_o        (back_busy),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  `PSR_NEVER(a_no_store_write_in_walk, ram_wr.en && back_busy, "weight written during a walk")
  `PSR_NEVER(a_no_queue_overflow, cmd_push && q_full, "command pushed into a full queue")
  `PSR_ASSERT(a_kept_result_single, m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0), "kept result malformed")

endmodule

@@ design/psr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module psr_ram #(
  parameter int unsigned DATA_W = 17,
  parameter int unsigned DEPTH  = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/psr_front.sv @@
// Front end: takes requests, stores weights, sums squares and forms run commands.
`timescale 1ns / 1ps
module psr_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // weight [16:0], start_offset [26:17], zero fill above
  input  logic [psr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind [0]
  input  logic                             s_axis_tuser,
  input  logic                             back_busy_i,
  input  logic                             q_empty_i,
  input  logic                             q_full_i,
  output logic                             cmd_push_o,
  output psr_pkg::cmd_t                    cmd_o,
  output psr_pkg::ram_wr_t                 ram_wr_o
);

  logic [psr_pkg::WEIGHT_W-1:0] weight;
  logic [psr_pkg::OFF_W-1:0]    offset;
  logic                         is_start;
  logic                         accept;
  logic                         store;
  logic [psr_pkg::BASE_W-1:0]   off_sat;
  logic [psr_pkg::BASE_W-1:0]   base;
  logic [psr_pkg::SQ_W:0]       sum_add;
  logic [psr_pkg::SQ_W-1:0]     eff_sum;
  logic [psr_pkg::PROD_W-1:0]   prod;

  logic [psr_pkg::CNT_W-1:0]    cnt_d, cnt_q;
  logic [psr_pkg::SQ_W-1:0]     sum_d, sum_q;
  logic                         sq_vld_d, sq_vld_q;
  logic                         st_vld_d, st_vld_q;
  logic [psr_pkg::SQR_W-1:0]    sq_q;
  logic [psr_pkg::SQ_W-1:0]     st_sum_q;
  logic [psr_pkg::BASE_W-1:0]   st_base_q;
  logic [psr_pkg::CNT_W-1:0]    st_cnt_q;

  assign weight   = s_axis_tdata[psr_pkg::WEIGHT_W-1:0];
  assign offset   = s_axis_tdata[psr_pkg::WEIGHT_W +: psr_pkg::OFF_W];
  assign is_start = (s_axis_tuser == psr_pkg::KIND_START);

  // Loads wait until no run still needs the stored weights.
  assign s_axis_tready = !st_vld_q && (is_start || (q_empty_i && !back_busy_i));
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign store         = accept && !is_start && (cnt_q < psr_pkg::CNT_W'(psr_pkg::PARTICLES));

  assign ram_wr_o.en   = store;
  assign ram_wr_o.addr = cnt_q[psr_pkg::IDX_W-1:0];
  assign ram_wr_o.data = weight;

  always_comb begin
    off_sat = psr_pkg::BASE_W'(offset);
    if (off_sat > psr_pkg::BASE_W'(psr_pkg::MAX_OFF)) begin
      off_sat = psr_pkg::BASE_W'(psr_pkg::MAX_OFF);
    end
  end

  assign base    = psr_pkg::BASE_W'(off_sat * psr_pkg::BASE_W'(psr_pkg::PARTICLES));
  assign sum_add = {1'b0, sum_q} + (psr_pkg::SQ_W + 1)'(sq_q);
  assign eff_sum = !sq_vld_q ? sum_q :
                   (sum_add[psr_pkg::SQ_W] ? {psr_pkg::SQ_W{1'b1}} :
                    sum_add[psr_pkg::SQ_W-1:0]);
  assign prod    = psr_pkg::PROD_W'(st_sum_q) * psr_pkg::PROD_W'(psr_pkg::PARTICLES);

  assign cmd_push_o    = st_vld_q && !q_full_i;
  assign cmd_o.base     = st_base_q;
  assign cmd_o.resample = (prod > psr_pkg::THRESH);
  assign cmd_o.cnt      = st_cnt_q;

  always_comb begin
    cnt_d    = cnt_q;
    sum_d    = eff_sum;
    sq_vld_d = 1'b0;
    st_vld_d = cmd_push_o ? 1'b0 : st_vld_q;
    if (store) begin
      cnt_d    = cnt_q + psr_pkg::CNT_W'(1);
      sq_vld_d = 1'b1;
    end
    if (accept && is_start) begin
      cnt_d    = '0;
      sum_d    = '0;
      st_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      sq_vld_q <= 1'b0;
      st_vld_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      sq_vld_q <= sq_vld_d;
      st_vld_q <= st_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      sq_q <= psr_pkg::SQR_W'(weight) * psr_pkg::SQR_W'(weight);
    end
    if (accept && is_start) begin
      st_sum_q  <= eff_sum;
      st_base_q <= base;
      st_cnt_q  <= cnt_q;
    end
  end

endmodule

@@ design/psr_fifo.sv @@
// Short command queue between the front end and the walk engine.
`timescale 1ns / 1ps
module psr_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  psr_pkg::cmd_t data_i,
  output logic          full_o,
  output logic          empty_o,
  input  logic          pop_i,
  output psr_pkg::cmd_t data_o
);

  psr_pkg::cmd_t               entry_q [psr_pkg::QUEUE_DEPTH];
  logic [psr_pkg::QPTR_W-1:0]  wr_ptr_d, wr_ptr_q;
  logic [psr_pkg::QPTR_W-1:0]  rd_ptr_d, rd_ptr_q;
  logic [psr_pkg::QCNT_W-1:0]  count_d, count_q;
  logic                        do_push;
  logic                        do_pop;

  assign full_o  = (count_q == psr_pkg::QCNT_W'(psr_pkg::QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == psr_pkg::QPTR_W'(psr_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wr_ptr_q + psr_pkg::QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == psr_pkg::QPTR_W'(psr_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 rd_ptr_q + psr_pkg::QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + psr_pkg::QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - psr_pkg::QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

@@ design/psr_back.sv @@
// Walk engine: steps the cumulative weights against evenly spaced pointers, or emits one kept result.
`timescale 1ns / 1ps
module psr_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_empty_i,
  input  psr_pkg::cmd_t                     cmd_i,
  output logic                              pop_o,
  output logic                              busy_o,
  output logic                              rd_en_o,
  output logic [psr_pkg::IDX_W-1:0]         rd_addr_o,
  input  logic [psr_pkg::WEIGHT_W-1:0]      rd_data_i,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // source_index [5:0], zero fill above
  output logic [psr_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
  // resampled [0]
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);

  psr_pkg::walk_state_e          state_d, state_q;
  logic [psr_pkg::IDX_W-1:0]     i_d, i_q;
  logic [psr_pkg::IDX_W-1:0]     m_d, m_q;
  logic [psr_pkg::CNT_W-1:0]     cnt_d, cnt_q;
  logic [psr_pkg::WALK_W-1:0]    u_d, u_q;
  logic [psr_pkg::WALK_W-1:0]    cum_d, cum_q;
  logic                          rd_ok_d, rd_ok_q;
  logic                          out_vld_d, out_vld_q;
  logic [psr_pkg::IDX_W-1:0]     out_idx_q;
  logic                          out_res_q;
  logic                          out_last_q;
  logic                          out_free;
  logic                          emit;
  logic [psr_pkg::IDX_W-1:0]     emit_idx;
  logic                          emit_res;
  logic                          emit_last;
  logic                          last_slot;

  assign busy_o    = (state_q != psr_pkg::ST_IDLE);
  assign out_free  = !out_vld_q || m_axis_tready;
  assign rd_addr_o = i_q;
  assign last_slot = (m_q == psr_pkg::IDX_W'(psr_pkg::PARTICLES - 1));

  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    m_d       = m_q;
    cnt_d     = cnt_q;
    u_d       = u_q;
    cum_d     = cum_q;
    rd_ok_d   = rd_ok_q;
    pop_o     = 1'b0;
    rd_en_o   = 1'b0;
    emit      = 1'b0;
    emit_idx  = '0;
    emit_res  = 1'b0;
    emit_last = 1'b1;
    case (state_q)
      psr_pkg::ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o   = 1'b1;
          cnt_d   = cmd_i.cnt;
          u_d     = psr_pkg::WALK_W'(cmd_i.base);
          cum_d   = '0;
          i_d     = '0;
          m_d     = '0;
          state_d = cmd_i.resample ? psr_pkg::ST_RD : psr_pkg::ST_SKIP;
        end
      end
      psr_pkg::ST_SKIP: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = psr_pkg::ST_IDLE;
        end
      end
      psr_pkg::ST_RD: begin
        rd_en_o = 1'b1;
        // Slots beyond the loaded count weigh zero; their read data is not accumulated.
        rd_ok_d = (psr_pkg::CNT_W'(i_q) < cnt_q);
        state_d = psr_pkg::ST_ACC;
      end
      psr_pkg::ST_ACC: begin
        if (rd_ok_q) begin
          cum_d = cum_q + psr_pkg::WALK_W'(psr_pkg::WALK_W'(rd_data_i) *
                                           psr_pkg::WALK_W'(psr_pkg::PARTICLES));
        end
        state_d = psr_pkg::ST_CMP;
      end
      psr_pkg::ST_CMP: begin
        if ((u_q > cum_q) && (i_q != psr_pkg::IDX_W'(psr_pkg::PARTICLES - 1))) begin
          i_d     = i_q + psr_pkg::IDX_W'(1);
          state_d = psr_pkg::ST_RD;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_idx  = i_q;
          emit_res  = 1'b1;
          emit_last = last_slot;
          u_d       = u_q + psr_pkg::WALK_W'(psr_pkg::STEP);
          m_d       = m_q + psr_pkg::IDX_W'(1);
          if (last_slot) begin
            state_d = psr_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = psr_pkg::ST_IDLE;
      end
    endcase
    out_vld_d = emit ? 1'b1 : (m_axis_tready ? 1'b0 : out_vld_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= psr_pkg::ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q     <= i_d;
    m_q     <= m_d;
    cnt_q   <= cnt_d;
    u_q     <= u_d;
    cum_q   <= cum_d;
    rd_ok_q <= rd_ok_d;
    if (emit) begin
      out_idx_q  <= emit_idx;
      out_res_q  <= emit_res;
      out_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = psr_pkg::OUT_DATA_W'(out_idx_q);
  assign m_axis_tuser  = out_res_q;
  assign m_axis_tlast  = out_last_q;

endmodule

@@ bench/particle_systematic_resampler_test.sv @@
// Self-checking testbench for the particle systematic resampler.
`timescale 1ns / 1ps
module particle_systematic_resampler_test;

  localparam longint unsigned SQ_SAT = (64'd1 << psr_pkg::SQ_W) - 1;
  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned RANDOM_ITEMS = 450;

  typedef struct {
    psr_pkg::kind_e               kind;
    logic [psr_pkg::WEIGHT_W-1:0] weight;
    logic [psr_pkg::OFF_W-1:0]    offset;
    bit                           drain;
  } request_t;

  typedef struct {
    logic [psr_pkg::IDX_W-1:0] source_index;
    logic                      resampled;
    logic                      last;
  } slot_result_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [psr_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                           s_axis_tuser = 1'b0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [psr_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tuser;
  logic                           m_axis_tlast;

  request_t                     request_queue[$];
  slot_result_t                 awaited_slots[$];
  logic                         slots_clear = 1'b1;
  bit                           failed = 1'b0;
  logic [psr_pkg::WEIGHT_W-1:0] particle_weight[psr_pkg::PARTICLES];
  int unsigned                  loaded_count = 0;
  longint unsigned              square_sum = 0;
  int unsigned                  send_gap = 0;
  int unsigned                  send_quiet = 0;
  int unsigned                  recv_gap = 0;
  int unsigned                  recv_quiet = 0;
  int unsigned                  stalled_cycles = 0;

  particle_systematic_resampler i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk_i = ~clk_i;

  function automatic int unsigned draw_gap(ref int unsigned quiet);
    int unsigned roll;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      quiet = $urandom_range(30, 80);
      return 0;
    end
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic longint unsigned weight_of(int unsigned idx);
    return (idx < loaded_count) ? longint'(particle_weight[idx]) : 0;
  endfunction

  function automatic void decide_and_walk(psr_pkg::kind_e kind,
                                          logic [psr_pkg::WEIGHT_W-1:0] w,
                                          logic [psr_pkg::OFF_W-1:0] off);
    longint unsigned sq;
    longint unsigned base;
    longint unsigned cum;
    longint unsigned ptr;
    int unsigned idx;
    slot_result_t slot;
    if (kind == psr_pkg::KIND_LOAD) begin
      if (loaded_count < psr_pkg::PARTICLES) begin
        particle_weight[loaded_count] = w;
        loaded_count++;
        sq = longint'(w) * longint'(w);
        if (sq > SQ_SAT - square_sum) square_sum = SQ_SAT;
        else square_sum += sq;
      end
      return;
    end
    if (longint'(psr_pkg::PARTICLES) * square_sum > 64'(psr_pkg::THRESH)) begin
      base = ((off > psr_pkg::MAX_OFF) ? psr_pkg::MAX_OFF : longint'(off)) *
             psr_pkg::PARTICLES;
      idx = 0;
      cum = weight_of(0) * psr_pkg::PARTICLES;
      for (int unsigned m = 0; m < psr_pkg::PARTICLES; m++) begin
        ptr = base + longint'(m) * psr_pkg::STEP;
        while (ptr > cum && idx < psr_pkg::PARTICLES - 1) begin
          idx++;
          cum += weight_of(idx) * psr_pkg::PARTICLES;
        end
        slot.source_index = idx[psr_pkg::IDX_W-1:0];
        slot.resampled = 1'b1;
        slot.last = (m == psr_pkg::PARTICLES - 1);
        awaited_slots = {awaited_slots, slot};
      end
    end else begin
      slot.source_index = '0;
      slot.resampled = 1'b0;
      slot.last = 1'b1;
      awaited_slots = {awaited_slots, slot};
    end
    loaded_count = 0;
    square_sum = 0;
  endfunction

  task automatic queue_load(input int unsigned w, input bit drain = 1'b0);
    request_t r;
    r.kind = psr_pkg::KIND_LOAD;
    r.weight = w[psr_pkg::WEIGHT_W-1:0];
    r.offset = psr_pkg::OFF_W'($urandom_range(0, 1023));
    r.drain = drain;
    request_queue = {request_queue, r};
  endtask

  task automatic queue_start(input int unsigned off, input bit drain = 1'b0);
    request_t r;
    r.kind = psr_pkg::KIND_START;
    r.weight = psr_pkg::WEIGHT_W'($urandom_range(0, 131071));
    r.offset = off[psr_pkg::OFF_W-1:0];
    r.drain = drain;
    request_queue = {request_queue, r};
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_axis_tready)) begin
      if (s_axis_tvalid) begin
        void'(request_queue.pop_front());
        send_gap = draw_gap(send_quiet);
      end
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (request_queue.size() == 0 ||
                   (request_queue[0].drain && (s_axis_tvalid || !slots_clear))) begin
        s_axis_tvalid <= 1'b0;
      end else begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= request_queue[0].kind;
        s_axis_tdata <= psr_pkg::IN_DATA_W'({request_queue[0].offset,
                                             request_queue[0].weight});
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) recv_gap = draw_gap(recv_quiet);
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    slot_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_slots.size() == 0) begin
          $error("unexpected result: source_index %0d", m_axis_tdata[psr_pkg::IDX_W-1:0]);
          failed = 1'b1;
        end else begin
          want = awaited_slots.pop_front();
          if (m_axis_tdata[psr_pkg::IDX_W-1:0] !== want.source_index) begin
            $error("source_index: expected %0d, actual %0d", want.source_index,
                   m_axis_tdata[psr_pkg::IDX_W-1:0]);
            failed = 1'b1;
          end
          if (m_axis_tuser !== want.resampled) begin
            $error("resampled: expected %0b, actual %0b", want.resampled, m_axis_tuser);
            failed = 1'b1;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last: expected %0b, actual %0b", want.last, m_axis_tlast);
            failed = 1'b1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        decide_and_walk(psr_pkg::kind_e'(s_axis_tuser),
                        s_axis_tdata[psr_pkg::WEIGHT_W-1:0],
                        s_axis_tdata[psr_pkg::WEIGHT_W +: psr_pkg::OFF_W]);
      slots_clear <= (awaited_slots.size() == 0);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        stalled_cycles = 0;
      else
        stalled_cycles++;
      if (stalled_cycles >= IDLE_LIMIT) begin
        $display("[particle_systematic_resampler] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int unsigned items;
    int unsigned run_len;
    int unsigned mode;
    int unsigned w;
    bit forced_drain;

    // Directed cases: empty run, single full weight, weight above 1.0, the exact
    // threshold and one step past it, pointers past the total weight, all zero.
    queue_start(0);
    queue_load(65536);
    queue_start(1023);
    queue_load(131071);
    queue_load(0);
    queue_start(0);
    queue_load(8192);
    queue_load(8192);
    queue_start(512);
    queue_load(8192);
    queue_load(8192);
    queue_load(1);
    queue_start(1023);
    queue_load(0);
    queue_load(0);
    queue_start(1023);
    queue_load(1024);
    queue_load(65535);
    queue_load(1024);
    queue_start(341);

    items = 0;
    forced_drain = 1'b1;
    while (items < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 99);
      if (mode < 5) run_len = 0;
      else if (mode < 80) run_len = $urandom_range(1, 12);
      else if (mode < 92) run_len = $urandom_range(13, 63);
      else run_len = psr_pkg::PARTICLES + $urandom_range(0, 6);
      mode = $urandom_range(0, 3);
      for (int unsigned i = 0; i < run_len; i++) begin
        case (mode)
          0: w = ($urandom_range(0, run_len - 1) == 0) ? $urandom_range(8192, 65536)
                                                       : $urandom_range(0, 512);
          1: w = $urandom_range(0, 131071 / run_len);
          2: w = $urandom_range(0, 131071);
          default: w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : 0;
        endcase
        queue_load(w, (i == 0) && (forced_drain || $urandom_range(0, 7) == 0));
        if (i == 0) forced_drain = 1'b0;
      end
      queue_start($urandom_range(0, 1023), run_len == 0 && $urandom_range(0, 3) == 0);
      items += ((run_len > psr_pkg::PARTICLES) ? psr_pkg::PARTICLES : run_len) + 1;
    end

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (request_queue.size() != 0 || awaited_slots.size() != 0) @(posedge clk_i);
    repeat (3 * psr_pkg::PARTICLES + 20) @(posedge clk_i);
    if (!failed && awaited_slots.size() == 0) begin
      $display("[particle_systematic_resampler] OK");
    end else begin
      $display("[particle_systematic_resampler] ERROR");
    end
    $finish;
  end

endmodule
